// ===== hw/rtl/pdr_pkg.sv =====
// pdr_pkg: shared types, constants and helper functions for the planar dead-reckoning integrator
// no dependencies; imported by pdr_mul, pdr_cordic and the top level
`timescale 1ns / 1ps

package pdr_pkg;

    // datapath widths
    localparam int VEL_W  = 27;  // cordic x/y word: speed with 8 guard bits plus gain headroom
    localparam int ANG_W  = 34;  // cordic angle word, Q2.30 with headroom
    localparam int MUL_AW = 28;
    localparam int MUL_BW = 24;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // fixed-point constants
    localparam int          PI_Q13        = 25736;
    localparam int          TWO_PI_Q13    = 51472;
    localparam longint      HALF_PI_Q30   = 64'd1686629713;
    localparam int          VEL_SCALE_Q24 = 2830004;
    localparam logic [15:0] STEP_RESET    = 16'd1311;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD_MUL,
        ST_HEAD_ACC,
        ST_ORIGIN,
        ST_ROTATE,
        ST_SCALE_X,
        ST_SCALE_Y,
        ST_STEP_X,
        ST_STEP_Y,
        ST_FINISH
    } t_state;

    // atan(2^-i) in Q2.30
    function automatic logic [30:0] pdr_atan(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:    v = 31'd843314857;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043837;
            5'd3:    v = 31'd133525159;
            5'd4:    v = 31'd67021687;
            5'd5:    v = 31'd33543516;
            5'd6:    v = 31'd16775851;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194283;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048576;
            5'd11:   v = 31'd524288;
            5'd12:   v = 31'd262144;
            5'd13:   v = 31'd131072;
            5'd14:   v = 31'd65536;
            5'd15:   v = 31'd32768;
            5'd16:   v = 31'd16384;
            5'd17:   v = 31'd8192;
            5'd18:   v = 31'd4096;
            5'd19:   v = 31'd2048;
            5'd20:   v = 31'd1024;
            5'd21:   v = 31'd512;
            5'd22:   v = 31'd256;
            5'd23:   v = 31'd128;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    // clamp a 34-bit sum to the signed 32-bit range
    function automatic logic signed [31:0] pdr_sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > $signed(34'h0_7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < $signed(34'h3_8000_0000)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/pdr_mul.sv =====
// pdr_mul: shared signed multiplier with a registered product
// depends on pdr_pkg for operand widths
`timescale 1ns / 1ps

module pdr_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [pdr_pkg::MUL_AW-1:0]    i_a,
    input  logic signed [pdr_pkg::MUL_BW-1:0]    i_b,
    output logic signed [pdr_pkg::MUL_PW-1:0]    o_p
);
    import pdr_pkg::*;

    logic signed [MUL_PW-1:0] r_p;

    // product holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/pdr_cordic.sv =====
// pdr_cordic: iterative cordic rotation, one micro-rotation per cycle
// depends on pdr_pkg for widths, the quarter-turn constant and the atan table
`timescale 1ns / 1ps

module pdr_cordic #(
    parameter int STAGES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [pdr_pkg::VEL_W-1:0]     i_x,
    input  logic signed [pdr_pkg::VEL_W-1:0]     i_y,
    input  logic signed [pdr_pkg::ANG_W-1:0]     i_z,
    output logic                                 o_done,
    output logic signed [pdr_pkg::VEL_W-1:0]     o_x,
    output logic signed [pdr_pkg::VEL_W-1:0]     o_y
);
    import pdr_pkg::*;

    localparam int IW = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam logic signed [ANG_W-1:0] HALF_PI = ANG_W'(HALF_PI_Q30);

    logic                     r_busy;
    logic                     r_done;
    logic [IW-1:0]            r_iter;
    logic signed [VEL_W-1:0]  r_x;
    logic signed [VEL_W-1:0]  r_y;
    logic signed [ANG_W-1:0]  r_z;

    logic signed [VEL_W-1:0]  pre_x;
    logic signed [VEL_W-1:0]  pre_y;
    logic signed [ANG_W-1:0]  pre_z;
    logic signed [VEL_W-1:0]  dx;
    logic signed [VEL_W-1:0]  dy;
    logic signed [ANG_W-1:0]  atan_v;

    // quarter-turn pre-rotation brings the angle into cordic range
    always_comb begin
        pre_x = i_x;
        pre_y = i_y;
        pre_z = i_z;
        if (i_z > HALF_PI) begin
            pre_x = -i_y;
            pre_y = i_x;
            pre_z = i_z - HALF_PI;
        end else if (i_z < -HALF_PI) begin
            pre_x = i_y;
            pre_y = -i_x;
            pre_z = i_z + HALF_PI;
        end
    end

    assign dx     = r_y >>> r_iter;
    assign dy     = r_x >>> r_iter;
    assign atan_v = $signed({{(ANG_W-31){1'b0}}, pdr_atan(5'(r_iter))});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_iter == IW'(STAGES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= pre_x;
            r_y    <= pre_y;
            r_z    <= pre_z;
            r_iter <= '0;
        end else if (r_busy) begin
            if (!r_z[ANG_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_v;
            end
            r_iter <= r_iter + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

// ===== hw/rtl/planar_dead_reckoning_integrator_top.sv =====
// planar_dead_reckoning_integrator_top: sequencer, state registers and result register
// depends on pdr_pkg, pdr_mul (shared multiplier) and pdr_cordic (iterative rotation)
`timescale 1ns / 1ps

// usage
// - input channel (i_in_valid / o_in_stall): one telemetry sample per transfer, all fields
//   held by the sender while stalled
// - output channel (o_out_valid / i_out_stall): one pose result per sample, values after
//   the update; the result sits in an output register until the receiver takes it
// - config channel (i_cfg_valid / o_cfg_ready): writes the integration step, always ready
//   outside reset; write only while the block is idle
// - a sample runs through the two heading products, the origin check, the cordic rotation
//   loop (one micro-rotation a cycle), the two scaling products and the two step products;
//   these six products share the single multiplier one after another
// - o_in_stall stays high from an input transfer until the block is back to idle, so
//   samples are taken one at a time and no new one is taken while the last is in flight
// - the next sample is taken while an earlier result still waits; if the receiver stalls,
//   the sequencer parks in its last step until the output register frees up
// - reset (synchronous, active low) clears pose, heading, track width, origin lock and
//   the previous lap distance, and sets the step to 1311 (0.020 s); stall is held high
//   and ready low while reset is asserted
module planar_dead_reckoning_integrator_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_step_time,
    // input sample
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [23:0]        i_lap_distance,
    input  logic signed [15:0] i_heading_rate,
    input  logic signed [15:0] i_lateral_position,
    input  logic [15:0]        i_left_edge_distance,
    input  logic [15:0]        i_right_edge_distance,
    input  logic signed [15:0] i_speed_forward,
    input  logic signed [15:0] i_speed_sideways,
    // result
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_position_x,
    output logic signed [31:0] o_position_y,
    output logic signed [15:0] o_heading,
    output logic               o_origin_locked
);
    import pdr_pkg::*;

    localparam logic signed [17:0] PI_18     = 18'(PI_Q13);
    localparam logic signed [17:0] TWO_PI_18 = 18'(TWO_PI_Q13);

    t_state r_state;
    t_state n_state;

    // architectural state
    logic [15:0]        r_step;
    logic [16:0]        r_width;
    logic               r_width_latched;
    logic               r_origin_set;
    logic [23:0]        r_prev_lap;
    logic signed [15:0] r_heading;
    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;

    // per-sample working registers
    logic [23:0]              r_lap;
    logic signed [15:0]       r_rate;
    logic signed [15:0]       r_lat;
    logic signed [15:0]       r_spd_f;
    logic signed [15:0]       r_spd_s;
    logic                     r_org_hit;
    logic signed [ANG_W-1:0]  r_z0;
    logic signed [23:0]       r_vx_s;
    logic signed [23:0]       r_vy_s;

    // result register
    logic               r_out_valid;
    logic signed [31:0] r_out_x;
    logic signed [31:0] r_out_y;
    logic signed [15:0] r_out_heading;
    logic               r_out_origin;

    // shared multiplier
    logic                       mul_en;
    logic signed [MUL_AW-1:0]   mul_a;
    logic signed [MUL_BW-1:0]   mul_b;
    logic signed [MUL_PW-1:0]   prod;

    // cordic
    logic                       cor_start;
    logic                       cor_done;
    logic signed [VEL_W-1:0]    cor_x;
    logic signed [VEL_W-1:0]    cor_y;
    logic signed [VEL_W-1:0]    cor_x_in;
    logic signed [VEL_W-1:0]    cor_y_in;

    // derived values
    logic               in_xfer;
    logic               out_free;
    logic signed [MUL_PW-1:0] rnd16;
    logic signed [MUL_PW-1:0] rnd15;
    logic signed [MUL_PW-1:0] rnd24;
    logic signed [MUL_PW-1:0] rnd22;
    logic signed [17:0] h_sum;
    logic signed [17:0] h_wrap;
    logic signed [33:0] pos_sum_x;
    logic signed [33:0] pos_sum_y;
    logic signed [31:0] pos_y_next;

    pdr_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    pdr_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_x     (cor_x_in),
        .i_y     (cor_y_in),
        .i_z     (r_z0),
        .o_done  (cor_done),
        .o_x     (cor_x),
        .o_y     (cor_y)
    );

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // speeds get 8 guard bits before rotation
    assign cor_x_in = $signed({{(VEL_W-24){r_spd_f[15]}}, r_spd_f, 8'b0});
    assign cor_y_in = $signed({{(VEL_W-24){r_spd_s[15]}}, r_spd_s, 8'b0});

    // round-half-up shifts of the shared product
    assign rnd16 = (prod + (52'sd1 <<< 15)) >>> 16;
    assign rnd15 = (prod + (52'sd1 <<< 14)) >>> 15;
    assign rnd24 = (prod + (52'sd1 <<< 23)) >>> 24;
    assign rnd22 = (prod + (52'sd1 <<< 21)) >>> 22;

    // heading update with a single wrap by 2pi
    assign h_sum = $signed({{2{r_heading[15]}}, r_heading}) + rnd16[17:0];
    always_comb begin
        h_wrap = h_sum;
        if (h_sum >= PI_18) begin
            h_wrap = h_sum - TWO_PI_18;
        end else if (h_sum < -PI_18) begin
            h_wrap = h_sum + TWO_PI_18;
        end
    end

    assign pos_sum_x  = $signed({{2{r_pos_x[31]}}, r_pos_x}) + rnd22[33:0];
    assign pos_sum_y  = $signed({{2{r_pos_y[31]}}, r_pos_y}) + rnd22[33:0];
    assign pos_y_next = pdr_sat32(pos_sum_y);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (in_xfer) n_state = ST_HEAD_MUL;
            ST_HEAD_MUL: n_state = ST_HEAD_ACC;
            ST_HEAD_ACC: n_state = ST_ORIGIN;
            ST_ORIGIN:   n_state = ST_ROTATE;
            ST_ROTATE:   if (cor_done) n_state = ST_SCALE_X;
            ST_SCALE_X:  n_state = ST_SCALE_Y;
            ST_SCALE_Y:  n_state = ST_STEP_X;
            ST_STEP_X:   n_state = ST_STEP_Y;
            ST_STEP_Y:   n_state = ST_FINISH;
            ST_FINISH:   if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // control outputs and multiplier operand select
    always_comb begin
        o_in_stall = (r_state != ST_IDLE) || !i_rst_n;
        cor_start  = 1'b0;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (r_state)
            ST_HEAD_MUL: begin
                mul_en = 1'b1;
                mul_a  = $signed({12'b0, r_step});
                mul_b  = $signed({{8{r_rate[15]}}, r_rate});
            end
            ST_HEAD_ACC: begin
                mul_en = 1'b1;
                mul_a  = $signed({{12{r_lat[15]}}, r_lat});
                mul_b  = $signed({7'b0, r_width});
            end
            ST_ORIGIN: begin
                cor_start = 1'b1;
            end
            ST_SCALE_X: begin
                mul_en = 1'b1;
                mul_a  = $signed({{(MUL_AW-VEL_W){cor_x[VEL_W-1]}}, cor_x});
                mul_b  = MUL_BW'(VEL_SCALE_Q24);
            end
            ST_SCALE_Y: begin
                mul_en = 1'b1;
                mul_a  = $signed({{(MUL_AW-VEL_W){cor_y[VEL_W-1]}}, cor_y});
                mul_b  = MUL_BW'(VEL_SCALE_Q24);
            end
            ST_STEP_X: begin
                mul_en = 1'b1;
                mul_a  = $signed({{4{r_vx_s[23]}}, r_vx_s});
                mul_b  = $signed({8'b0, r_step});
            end
            ST_STEP_Y: begin
                mul_en = 1'b1;
                mul_a  = $signed({{4{r_vy_s[23]}}, r_vy_s});
                mul_b  = $signed({8'b0, r_step});
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign o_cfg_ready = i_rst_n;

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_step          <= STEP_RESET;
            r_width         <= '0;
            r_width_latched <= 1'b0;
            r_origin_set    <= 1'b0;
            r_prev_lap      <= '0;
            r_heading       <= '0;
            r_pos_x         <= '0;
            r_pos_y         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_step <= i_cfg_step_time;
            end
            // a new result replaces the one taken in the same cycle
            if (r_state == ST_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        // track width is taken from the first sample only
                        if (!r_width_latched) begin
                            r_width         <= {1'b0, i_left_edge_distance}
                                             + {1'b0, i_right_edge_distance};
                            r_width_latched <= 1'b1;
                        end
                        r_prev_lap <= i_lap_distance;
                    end
                end
                ST_HEAD_ACC: begin
                    r_heading <= h_wrap[15:0];
                end
                ST_ORIGIN: begin
                    // first lap wrap pins the origin
                    if (r_org_hit) begin
                        r_pos_x      <= $signed({8'b0, r_lap});
                        r_pos_y      <= rnd15[31:0];
                        r_origin_set <= 1'b1;
                    end
                end
                ST_STEP_Y: begin
                    r_pos_x <= pdr_sat32(pos_sum_x);
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_pos_y <= pos_y_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_lap     <= i_lap_distance;
            r_rate    <= i_heading_rate;
            r_lat     <= i_lateral_position;
            r_spd_f   <= i_speed_forward;
            r_spd_s   <= i_speed_sideways;
            r_org_hit <= !r_origin_set && (i_lap_distance < r_prev_lap);
        end
        if (r_state == ST_HEAD_ACC) begin
            // heading in Q2.30 for the rotation
            r_z0 <= $signed({h_wrap[15], h_wrap[15:0], 17'b0});
        end
        if (r_state == ST_SCALE_Y) begin
            r_vx_s <= rnd24[23:0];
        end
        if (r_state == ST_STEP_X) begin
            r_vy_s <= rnd24[23:0];
        end
        if (r_state == ST_FINISH && out_free) begin
            r_out_x       <= r_pos_x;
            r_out_y       <= pos_y_next;
            r_out_heading <= r_heading;
            r_out_origin  <= r_origin_set;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_position_x    = r_out_x;
    assign o_position_y    = r_out_y;
    assign o_heading       = r_out_heading;
    assign o_origin_locked = r_out_origin;

endmodule
